@@ rtl/isd_pkg.sv @@
// Shared types and constants for the IMU struggle detector.
package isd_pkg;

   localparam int unsigned ACCEL_W = 15;
   localparam int unsigned GYRO_W  = 16;
   localparam int unsigned JERK_W  = 27;
   localparam int unsigned CONF_W  = 7;

   localparam logic [1:0] REG_ACCEL_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_GYRO_THRESHOLD  = 2'd1;
   localparam logic [1:0] REG_HITS_NEEDED     = 2'd2;
   localparam logic [1:0] REG_JERK_RATE       = 2'd3;

   localparam logic [ACCEL_W-1:0] PREV_ACCEL_RESET = 15'd1024;
   localparam logic [15:0]        JERK_FULL_SCALE  = 16'd10240;
   // 2^32 / 10240 rounded up: (j * JERK_RECIP) >> 16 is floor(j * 65536 / 10240) for j <= 10240
   localparam logic [18:0]        JERK_RECIP       = 19'd419431;

   typedef struct packed {
      logic [ACCEL_W-1:0] am;
      logic [GYRO_W-1:0]  gm;
   } mag_type;

   typedef struct packed {
      logic [14:0] accel_threshold;
      logic [15:0] gyro_threshold;
      logic [9:0]  hits_needed;
      logic [11:0] jerk_rate;
      logic        clear_hits;
   } cfg_type;

   typedef enum logic [1:0] {F_IDLE, F_SQUARE, F_ROOT, F_PUSH} front_state_type;
   typedef enum logic [1:0] {B_IDLE, B_PREP, B_LOAD, B_DIV} back_state_type;

endpackage

@@ rtl/isd_front.sv @@
// Front end: takes a sample, sums squares on one multiplier, two bit-serial square roots.
module isd_front
   import isd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [14:0] req_accel_x,
   input  logic signed [14:0] req_accel_y,
   input  logic signed [14:0] req_accel_z,
   input  logic signed [15:0] req_rate_x,
   input  logic signed [15:0] req_rate_y,
   input  logic signed [15:0] req_rate_z,
   output logic               push,
   output mag_type            push_data,
   input  logic               q_full
);

   front_state_type state_ff, state_in;
   logic [2:0]  step_ff, step_in;
   logic [3:0]  rcnt_ff, rcnt_in;
   logic [15:0] op_ff [6];
   logic [15:0] op_in [6];
   logic [31:0] n_ff [2];
   logic [31:0] n_in [2];
   logic [17:0] rem_ff [2];
   logic [17:0] rem_in [2];
   logic [15:0] root_ff [2];
   logic [15:0] root_in [2];
   logic [31:0] prod;
   logic [17:0] trial [2];
   logic [17:0] tsub [2];

   function automatic logic [15:0] abs15(input logic [14:0] v);
      logic [14:0] m;
      m = v[14] ? (~v + 15'd1) : v;
      return {1'b0, m};
   endfunction

   function automatic logic [15:0] abs16(input logic [15:0] v);
      return v[15] ? (~v + 16'd1) : v;
   endfunction

   assign prod      = op_ff[step_ff] * op_ff[step_ff];
   assign req_ready = (state_ff == F_IDLE);
   assign push      = (state_ff == F_PUSH) && !q_full;
   assign push_data = '{am: root_ff[0][14:0], gm: root_ff[1]};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rcnt_in  = rcnt_ff;
      op_in    = op_ff;
      n_in     = n_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      for (int i = 0; i < 2; i++) begin
         trial[i] = {rem_ff[i][15:0], n_ff[i][31:30]};
         tsub[i]  = {root_ff[i], 2'b01};
      end
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               op_in[0] = abs15(req_accel_x);
               op_in[1] = abs15(req_accel_y);
               op_in[2] = abs15(req_accel_z);
               op_in[3] = abs16(req_rate_x);
               op_in[4] = abs16(req_rate_y);
               op_in[5] = abs16(req_rate_z);
               n_in[0]  = '0;
               n_in[1]  = '0;
               step_in  = '0;
               state_in = F_SQUARE;
            end
         end
         F_SQUARE: begin
            // n holds the running sum of squares until the roots start
            if (step_ff < 3'd3) n_in[0] = n_ff[0] + prod;
            else                n_in[1] = n_ff[1] + prod;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               step_in    = '0;
               rem_in[0]  = '0;
               rem_in[1]  = '0;
               root_in[0] = '0;
               root_in[1] = '0;
               rcnt_in    = '0;
               state_in   = F_ROOT;
            end
         end
         F_ROOT: begin
            for (int i = 0; i < 2; i++) begin
               n_in[i] = {n_ff[i][29:0], 2'b00};
               if (trial[i] >= tsub[i]) begin
                  rem_in[i]  = trial[i] - tsub[i];
                  root_in[i] = {root_ff[i][14:0], 1'b1};
               end else begin
                  rem_in[i]  = trial[i];
                  root_in[i] = {root_ff[i][14:0], 1'b0};
               end
            end
            rcnt_in = rcnt_ff + 4'd1;
            if (rcnt_ff == 4'd15) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      rcnt_ff <= rcnt_in;
      op_ff   <= op_in;
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule

@@ rtl/isd_queue.sv @@
// Two-entry queue of magnitude pairs between front and back end.
module isd_queue
   import isd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  mag_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output mag_type pop_data
);

   mag_type    mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

@@ rtl/isd_back.sv @@
// Back end: jerk, shared serial divider for the ratios, hit counter and result register.
module isd_back
   import isd_pkg::*;
#(
   parameter int unsigned HIT_COUNTER_BITS = 10
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_not_empty,
   input  mag_type     q_data,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_struggle,
   output logic        rsp_struggle_active,
   output logic [6:0]  rsp_confidence,
   output logic [14:0] rsp_accel_magnitude,
   output logic [15:0] rsp_gyro_magnitude,
   output logic [26:0] rsp_jerk_value
);

   localparam int unsigned CW = (HIT_COUNTER_BITS > 10) ? HIT_COUNTER_BITS : 10;
   localparam logic [HIT_COUNTER_BITS-1:0] CMAX = {HIT_COUNTER_BITS{1'b1}};

   back_state_type state_ff, state_in;
   logic [14:0] am_ff, am_in;
   logic [15:0] gm_ff, gm_in;
   logic        hit_ff, hit_in;
   logic [26:0] jerk_ff, jerk_in;
   logic [14:0] prev_ff, prev_in;
   logic [HIT_COUNTER_BITS-1:0] cnt_ff, cnt_in;
   logic        act_ff, act_in;
   logic        sel_ff, sel_in;
   logic [4:0]  bit_ff, bit_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [19:0] q_ff, q_in;
   logic        vld_ff, vld_in;
   logic        str_ff, str_in;
   logic        sact_ff, sact_in;
   logic [6:0]  conf_ff, conf_in;
   logic [14:0] oam_ff, oam_in;
   logic [15:0] ogm_ff, ogm_in;
   logic [26:0] ojk_ff, ojk_in;

   logic [14:0] diff;
   logic [16:0] trial;
   logic        ge;
   logic [31:0] quo;
   logic [19:0] qsat;
   logic [15:0] ta_d, tg_d;
   logic [13:0] jm;
   logic [32:0] ejp;
   logic        deliver;
   logic [16:0] ea, eg, ej;
   logic [23:0] wsum;
   logic [7:0]  conf_h;
   logic [20:0] rsum;
   logic [25:0] rprod;
   logic [9:0]  conf_p;
   logic        near;
   logic [HIT_COUNTER_BITS-1:0] cnt_next;

   assign ta_d = (cfg.accel_threshold == '0) ? 16'd1 : {1'b0, cfg.accel_threshold};
   assign tg_d = (cfg.gyro_threshold == '0) ? 16'd1 : cfg.gyro_threshold;
   assign diff = (am_ff > prev_ff) ? am_ff - prev_ff : prev_ff - am_ff;
   assign jm   = (jerk_ff >= 27'(JERK_FULL_SCALE)) ? JERK_FULL_SCALE[13:0] : jerk_ff[13:0];
   // jerk ratio by reciprocal multiply, no divider pass
   assign ejp  = 33'(jm) * 33'(JERK_RECIP);

   assign trial = {rem_ff, dvd_ff[31]};
   assign ge    = (trial >= {1'b0, dvs_ff});
   assign quo   = {dvd_ff[30:0], ge};
   assign qsat  = (quo[31:19] != '0) ? 20'h80000 : quo[19:0];

   assign pop       = (state_ff == B_IDLE) && q_not_empty;
   assign rsp_valid = vld_ff;
   // the last divide step hands the result straight to the output register
   assign deliver   = (state_ff == B_DIV) && (bit_ff == 5'd31) && sel_ff
                      && (!vld_ff || rsp_ready);

   always_comb begin
      ea = (q_ff > 20'h10000) ? 17'h10000 : q_ff[16:0];
      eg = (qsat > 20'h10000) ? 17'h10000 : qsat[16:0];
      ej = ejp[32:16];
      wsum = 24'(ea) * 24'd40 + 24'(eg) * 24'd35 + 24'(ej) * 24'd25;
      conf_h = 8'd50 + {1'b0, wsum[23:17]};
      rsum  = {1'b0, q_ff} + {1'b0, qsat};
      rprod = 26'(rsum) * 26'd20;
      conf_p = rprod[25:16];
      near = ({4'b0, am_ff} * 19'd10 > {4'b0, cfg.accel_threshold} * 19'd7)
          || ({4'b0, gm_ff} * 20'd10 > {4'b0, cfg.gyro_threshold} * 20'd7);
      if (hit_ff) cnt_next = (cnt_ff < CMAX) ? cnt_ff + 1'b1 : cnt_ff;
      else        cnt_next = (cnt_ff != '0) ? cnt_ff - 1'b1 : cnt_ff;
   end

   always_comb begin
      state_in = state_ff;
      am_in    = am_ff;
      gm_in    = gm_ff;
      hit_in   = hit_ff;
      jerk_in  = jerk_ff;
      prev_in  = prev_ff;
      cnt_in   = cnt_ff;
      act_in   = act_ff;
      sel_in   = sel_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      q_in     = q_ff;
      vld_in   = (vld_ff && rsp_ready) ? 1'b0 : vld_ff;
      str_in   = str_ff;
      sact_in  = sact_ff;
      conf_in  = conf_ff;
      oam_in   = oam_ff;
      ogm_in   = ogm_ff;
      ojk_in   = ojk_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_not_empty) begin
               am_in    = q_data.am;
               gm_in    = q_data.gm;
               state_in = B_PREP;
            end
         end
         B_PREP: begin
            jerk_in  = 27'(diff) * 27'(cfg.jerk_rate);
            hit_in   = (am_ff > cfg.accel_threshold) && (gm_ff > cfg.gyro_threshold);
            sel_in   = 1'b0;
            state_in = B_LOAD;
         end
         B_LOAD: begin
            rem_in = '0;
            bit_in = '0;
            case (sel_ff)
               1'b0: begin
                  dvd_in = hit_ff ? {1'b0, am_ff - cfg.accel_threshold, 16'b0}
                                  : {1'b0, am_ff, 16'b0};
                  dvs_in = ta_d;
               end
               default: begin
                  dvd_in = hit_ff ? {gm_ff - cfg.gyro_threshold, 16'b0} : {gm_ff, 16'b0};
                  dvs_in = tg_d;
               end
            endcase
            state_in = B_DIV;
         end
         B_DIV: begin
            rem_in = ge ? 16'(trial - {1'b0, dvs_ff}) : trial[15:0];
            dvd_in = quo;
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'd31) begin
               if (!sel_ff) begin
                  q_in     = qsat;
                  sel_in   = 1'b1;
                  state_in = B_LOAD;
               end else if (deliver) begin
                  state_in = B_IDLE;
                  vld_in   = 1'b1;
                  oam_in   = am_ff;
                  ogm_in   = gm_ff;
                  ojk_in   = jerk_ff;
                  prev_in  = am_ff;
                  cnt_in   = cnt_next;
                  str_in   = 1'b0;
                  if (hit_ff) begin
                     conf_in = (conf_h > 8'd100) ? 7'd100 : conf_h[6:0];
                     if (CW'(cnt_next) >= CW'(cfg.hits_needed)) begin
                        str_in = 1'b1;
                        act_in = 1'b1;
                     end
                  end else begin
                     conf_in = !near ? 7'd0 : (conf_p > 10'd100) ? 7'd100 : conf_p[6:0];
                     if (cnt_next == '0) act_in = 1'b0;
                  end
                  sact_in = act_in;
               end else begin
                  // output slot busy: hold the last step until it frees
                  rem_in = rem_ff;
                  dvd_in = dvd_ff;
                  bit_in = bit_ff;
                  q_in   = q_ff;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
      if (cfg.clear_hits) cnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         prev_ff  <= PREV_ACCEL_RESET;
         cnt_ff   <= '0;
         act_ff   <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
         cnt_ff   <= cnt_in;
         act_ff   <= act_in;
         vld_ff   <= vld_in;
      end
      am_ff   <= am_in;
      gm_ff   <= gm_in;
      hit_ff  <= hit_in;
      jerk_ff <= jerk_in;
      sel_ff  <= sel_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      q_ff    <= q_in;
      str_ff  <= str_in;
      sact_ff <= sact_in;
      conf_ff <= conf_in;
      oam_ff  <= oam_in;
      ogm_ff  <= ogm_in;
      ojk_ff  <= ojk_in;
   end

   assign rsp_is_struggle     = str_ff;
   assign rsp_struggle_active = sact_ff;
   assign rsp_confidence      = conf_ff;
   assign rsp_accel_magnitude = oam_ff;
   assign rsp_gyro_magnitude  = ogm_ff;
   assign rsp_jerk_value      = ojk_ff;

endmodule

@@ rtl/imu_struggle_detector_top.sv @@
// Top level of the IMU struggle detector: CSRs, front end, queue and back end.
//
//  channel  direction  handshake               payload
//  req      in         req_valid / req_ready   accel_x/y/z, rate_x/y/z
//  rsp      out        rsp_valid / rsp_ready   is_struggle .. jerk_value
//  csr      in         csr_write_en            csr_index, csr_write_data
//
// Front end: accept, six squares on the shared squaring multiplier, 16 steps
// of the two bit-serial roots, then push; it takes no new sample before the push.
// Back end: two 32-step serial divisions a beat; that sets the rate.
// Synchronous reset, no clearing pass. A busy result register stalls the back end,
// a full queue stalls the front end, and req_ready then stays low.
module imu_struggle_detector_top
   import isd_pkg::*;
#(
   parameter int unsigned HIT_COUNTER_BITS = 10
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [14:0] req_accel_x,
   input  logic signed [14:0] req_accel_y,
   input  logic signed [14:0] req_accel_z,
   input  logic signed [15:0] req_rate_x,
   input  logic signed [15:0] req_rate_y,
   input  logic signed [15:0] req_rate_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_struggle,
   output logic               rsp_struggle_active,
   output logic [6:0]         rsp_confidence,
   output logic [14:0]        rsp_accel_magnitude,
   output logic [15:0]        rsp_gyro_magnitude,
   output logic [26:0]        rsp_jerk_value,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   logic [14:0] ath_ff;
   logic [15:0] gth_ff;
   logic [9:0]  hits_ff;
   logic [11:0] rate_ff;
   cfg_type     cfg;
   logic        push, q_full, pop, q_not_empty;
   mag_type     push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         ath_ff  <= 15'd2048;
         gth_ff  <= 16'd4000;
         hits_ff <= 10'd3;
         rate_ff <= 12'd50;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_ACCEL_THRESHOLD: ath_ff  <= csr_write_data[14:0];
            REG_GYRO_THRESHOLD:  gth_ff  <= csr_write_data;
            REG_HITS_NEEDED:     hits_ff <= csr_write_data[9:0];
            REG_JERK_RATE:       rate_ff <= csr_write_data[11:0];
            default: ;
         endcase
      end
   end

   assign cfg = '{accel_threshold: ath_ff, gyro_threshold: gth_ff, hits_needed: hits_ff,
                  jerk_rate: rate_ff,
                  clear_hits: csr_write_en && (csr_index != REG_JERK_RATE)};

   isd_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_accel_x(req_accel_x), .req_accel_y(req_accel_y), .req_accel_z(req_accel_z),
      .req_rate_x(req_rate_x), .req_rate_y(req_rate_y), .req_rate_z(req_rate_z),
      .push(push), .push_data(push_data), .q_full(q_full)
   );

   isd_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .full(q_full),
      .pop(pop), .not_empty(q_not_empty), .pop_data(pop_data)
   );

   isd_back #(.HIT_COUNTER_BITS(HIT_COUNTER_BITS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .q_not_empty(q_not_empty), .q_data(pop_data), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_is_struggle(rsp_is_struggle), .rsp_struggle_active(rsp_struggle_active),
      .rsp_confidence(rsp_confidence), .rsp_accel_magnitude(rsp_accel_magnitude),
      .rsp_gyro_magnitude(rsp_gyro_magnitude), .rsp_jerk_value(rsp_jerk_value)
   );

endmodule
